FILE: rtl/tcphop_pkg.sv
// Package: shared constants and types for the TCP header and option parser.
package tcphop_pkg;

   localparam logic [5:0] FIXED_LEN = 6'd20;

   // byte offsets of the fixed header fields
   localparam logic [5:0] POS_DST   = 6'd2;
   localparam logic [5:0] POS_SEQ   = 6'd4;
   localparam logic [5:0] POS_ACK   = 6'd8;
   localparam logic [5:0] POS_OFF   = 6'd12;
   localparam logic [5:0] POS_FLAGS = 6'd13;
   localparam logic [5:0] POS_WIN   = 6'd14;
   localparam logic [5:0] POS_CSUM  = 6'd16;
   localparam logic [5:0] POS_URG   = 6'd18;

   localparam logic [3:0] MIN_OFFSET = 4'd5;

   // option kind bytes
   localparam logic [7:0] OPT_EOL    = 8'd0;
   localparam logic [7:0] OPT_NOOP   = 8'd1;
   localparam logic [7:0] OPT_MSS    = 8'd2;
   localparam logic [7:0] OPT_WSCALE = 8'd3;

   // option length limits
   localparam logic [7:0] OPT_LEN_MIN    = 8'd2;
   localparam logic [7:0] MSS_LEN_MIN    = 8'd4;
   localparam logic [7:0] WSCALE_LEN_MIN = 8'd3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SHORT     = 2'd1,
      STATUS_TRUNCATED = 2'd2,
      STATUS_MALFORMED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PHASE_KIND,
      PHASE_LEN,
      PHASE_FIRST,
      PHASE_MORE
   } phase_type;

   typedef enum logic [1:0] {
      CAPT_NONE,
      CAPT_MSS,
      CAPT_WSCALE
   } capt_type;

   typedef struct packed {
      logic step;     // a header byte past the fixed part is taken
      logic clear;    // segment ends: restart the walk
   } walk_ctl_type;

   typedef struct packed {
      logic [15:0] mss;
      logic [7:0]  wscale;
      logic [1:0]  found;
      logic        malformed;
   } opt_view_type;

endpackage

FILE: rtl/tcphop_if.sv
// Interfaces: request and response channels of the TCP header parser.
interface tcphop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] segment_byte;
   logic       last_byte;

   modport source (output valid, output segment_byte, output last_byte, input ready);
   modport sink   (input valid, input segment_byte, input last_byte, output ready);
endinterface

interface tcphop_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [31:0] sequence_number;
   logic [31:0] ack_number;
   logic [9:0]  flag_bits;
   logic [15:0] window_size;
   logic [15:0] header_checksum;
   logic [5:0]  header_bytes;
   logic [15:0] max_segment_size;
   logic [7:0]  window_scale;
   logic [1:0]  options_found;
   logic [1:0]  parse_status;

   modport source (output valid, output source_port, output dest_port,
                   output sequence_number, output ack_number, output flag_bits,
                   output window_size, output header_checksum, output header_bytes,
                   output max_segment_size, output window_scale, output options_found,
                   output parse_status, input ready);
   modport sink   (input valid, input source_port, input dest_port,
                   input sequence_number, input ack_number, input flag_bits,
                   input window_size, input header_checksum, input header_bytes,
                   input max_segment_size, input window_scale, input options_found,
                   input parse_status, output ready);
endinterface

FILE: rtl/tcphop_opt_walk.sv
// Option walker: TCP option state machine and captured MSS / window scale values.
module tcphop_opt_walk
   import tcphop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  walk_ctl_type ctl,
   input  logic [7:0]   opt_byte,
   input  logic [5:0]   remaining,   // header bytes left, this one included
   output opt_view_type view_next    // option view after this byte
);

   phase_type    phase_ff, phase_in;
   capt_type     capt_ff, capt_in;
   logic [5:0]   left_ff, left_in;
   logic         stopped_ff, stopped_in;
   opt_view_type view_ff, view_in;

   logic [7:0] rem_plus1;
   logic [5:0] left_dec;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PHASE_KIND;
         capt_ff    <= CAPT_NONE;
         left_ff    <= '0;
         stopped_ff <= 1'b0;
         view_ff    <= '0;
      end else if (ctl.clear) begin
         phase_ff   <= PHASE_KIND;
         capt_ff    <= CAPT_NONE;
         left_ff    <= '0;
         stopped_ff <= 1'b0;
         view_ff    <= '0;
      end else begin
         phase_ff   <= phase_in;
         capt_ff    <= capt_in;
         left_ff    <= left_in;
         stopped_ff <= stopped_in;
         view_ff    <= view_in;
      end
   end

   always_comb begin
      phase_in   = phase_ff;
      capt_in    = capt_ff;
      left_in    = left_ff;
      stopped_in = stopped_ff;
      view_in    = view_ff;
      rem_plus1  = {2'b00, remaining} + 8'd1;
      left_dec   = left_ff - 6'd1;

      if (ctl.step && !stopped_ff) begin
         unique case (phase_ff)
            PHASE_KIND: begin
               if (opt_byte == OPT_EOL) begin
                  stopped_in = 1'b1;
               end else if (opt_byte == OPT_NOOP) begin
                  phase_in = PHASE_KIND;
               end else if (remaining < 6'd2) begin
                  stopped_in        = 1'b1;
                  view_in.malformed = 1'b1;
               end else begin
                  if (opt_byte == OPT_MSS) begin
                     capt_in = CAPT_MSS;
                  end else if (opt_byte == OPT_WSCALE) begin
                     capt_in = CAPT_WSCALE;
                  end else begin
                     capt_in = CAPT_NONE;
                  end
                  phase_in = PHASE_LEN;
               end
            end
            PHASE_LEN: begin
               if (opt_byte < OPT_LEN_MIN || opt_byte > rem_plus1) begin
                  stopped_in        = 1'b1;
                  view_in.malformed = 1'b1;
               end else begin
                  left_in = 6'(opt_byte - OPT_LEN_MIN);
                  // drop captures whose option is too short to carry the value
                  if ((capt_ff == CAPT_MSS && opt_byte < MSS_LEN_MIN) ||
                      (capt_ff == CAPT_WSCALE && opt_byte < WSCALE_LEN_MIN)) begin
                     capt_in = CAPT_NONE;
                  end
                  phase_in = (opt_byte > OPT_LEN_MIN) ? PHASE_FIRST : PHASE_KIND;
               end
            end
            PHASE_FIRST, PHASE_MORE: begin
               if (capt_ff == CAPT_MSS) begin
                  if (phase_ff == PHASE_FIRST) begin
                     view_in.mss      = {opt_byte, 8'h00};
                     view_in.found[0] = 1'b1;
                  end else begin
                     view_in.mss[7:0] = opt_byte;
                     capt_in          = CAPT_NONE;
                  end
               end else if (capt_ff == CAPT_WSCALE) begin
                  view_in.wscale   = opt_byte;
                  view_in.found[1] = 1'b1;
                  capt_in          = CAPT_NONE;
               end
               left_in  = left_dec;
               phase_in = (left_dec == 6'd0) ? PHASE_KIND : PHASE_MORE;
            end
            default: phase_in = PHASE_KIND;
         endcase
      end
   end

   assign view_next = view_in;

endmodule

FILE: rtl/tcp_header_option_parser.sv
// Top level: TCP header field extractor with option walk, one byte per request.
//
//   channel | direction | payload                                | handshake
//   req_bus | in        | segment_byte, last_byte                | valid / ready
//   rsp_bus | out       | header fields, options, parse_status   | valid / ready
//
// One byte is taken per cycle; only a byte that completes a summary needs the
// response register free or being drained.
// A request is registered, then processed from that register against the segment
// state; a summary response is then written into the response register.
// Reset (synchronous, active high) clears the segment state and both valid flags.
// A stalled response holds the request stage only when the waiting byte ends a
// header, or ends a segment whose header is unfinished; other bytes keep flowing.
module tcp_header_option_parser
   import tcphop_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   tcphop_req_if.sink   req_bus,
   tcphop_rsp_if.source rsp_bus
);

   // request stage
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   // segment state
   logic [5:0] idx_ff, idx_in;
   logic       done_ff, done_in;

   // fixed header fields
   logic [15:0] src_port_ff;
   logic [15:0] dst_port_ff;
   logic [31:0] seq_ff;
   logic [31:0] ack_ff;
   logic [3:0]  offset_ff;
   logic [9:0]  flags_ff;
   logic [15:0] window_ff;
   logic [15:0] csum_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] r_src_ff, r_dst_ff, r_win_ff, r_csum_ff, r_mss_ff;
   logic [31:0] r_seq_ff, r_ack_ff;
   logic [9:0]  r_flags_ff;
   logic [5:0]  r_hbytes_ff;
   logic [7:0]  r_wscale_ff;
   logic [1:0]  r_found_ff;
   status_type  r_status_ff;

   logic         proc;
   logic [5:0]   idx_inc;
   logic [5:0]   eff_hlen;
   logic [5:0]   remaining;
   logic         hdr_end;
   logic         would_emit;
   logic         emit;
   status_type   status;
   walk_ctl_type walk_ctl;
   opt_view_type opt_view;

   assign idx_inc   = idx_ff + 6'd1;
   assign eff_hlen  = (offset_ff < MIN_OFFSET) ? FIXED_LEN : {offset_ff, 2'b00};
   assign remaining = eff_hlen - idx_ff;

   assign hdr_end    = !done_ff && (idx_inc >= FIXED_LEN) && (idx_inc == eff_hlen);
   assign would_emit = hdr_end || (in_last_ff && !done_ff);

   // hold a summary byte only while an older response still waits
   assign proc        = in_valid_ff && (!would_emit || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || proc;

   assign walk_ctl.step  = proc && !done_ff && (idx_ff >= FIXED_LEN);
   assign walk_ctl.clear = proc && in_last_ff;

   tcphop_opt_walk u_walk (
      .clock     (clock),
      .reset     (reset),
      .ctl       (walk_ctl),
      .opt_byte  (in_byte_ff),
      .remaining (remaining),
      .view_next (opt_view)
   );

   always_comb begin
      emit = proc && would_emit;
      if (hdr_end) begin
         status = opt_view.malformed ? STATUS_MALFORMED : STATUS_OK;
      end else if (idx_inc < FIXED_LEN) begin
         status = STATUS_SHORT;
      end else begin
         status = STATUS_TRUNCATED;
      end

      in_valid_in = in_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         in_valid_in = 1'b1;
      end else if (proc) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      idx_in  = idx_ff;
      done_in = done_ff;
      if (proc) begin
         if (in_last_ff) begin
            idx_in  = '0;
            done_in = 1'b0;
         end else if (!done_ff) begin
            idx_in  = idx_inc;
            done_in = hdr_end;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         done_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         done_ff      <= done_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         in_byte_ff <= req_bus.segment_byte;
         in_last_ff <= req_bus.last_byte;
      end
   end

   // capture the fixed header bytes at their offsets
   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else if (proc && in_last_ff) begin
         offset_ff <= '0;
      end else if (proc && !done_ff && idx_ff == POS_OFF) begin
         offset_ff <= in_byte_ff[7:4];
      end
   end

   always_ff @(posedge clock) begin
      if (proc && !done_ff && idx_ff < FIXED_LEN) begin
         if (idx_ff < POS_DST) begin
            src_port_ff <= {src_port_ff[7:0], in_byte_ff};
         end else if (idx_ff < POS_SEQ) begin
            dst_port_ff <= {dst_port_ff[7:0], in_byte_ff};
         end else if (idx_ff < POS_ACK) begin
            seq_ff <= {seq_ff[23:0], in_byte_ff};
         end else if (idx_ff < POS_OFF) begin
            ack_ff <= {ack_ff[23:0], in_byte_ff};
         end else if (idx_ff == POS_OFF) begin
            flags_ff[9:8] <= in_byte_ff[1:0];
         end else if (idx_ff == POS_FLAGS) begin
            flags_ff[7:0] <= in_byte_ff;
         end else if (idx_ff < POS_CSUM) begin
            window_ff <= {window_ff[7:0], in_byte_ff};
         end else if (idx_ff < POS_URG) begin
            csum_ff <= {csum_ff[7:0], in_byte_ff};
         end
      end
   end

   // response register; a short segment reports zeros beside its status
   always_ff @(posedge clock) begin
      if (emit) begin
         r_status_ff <= status;
         if (status == STATUS_SHORT) begin
            r_src_ff    <= '0;
            r_dst_ff    <= '0;
            r_seq_ff    <= '0;
            r_ack_ff    <= '0;
            r_flags_ff  <= '0;
            r_win_ff    <= '0;
            r_csum_ff   <= '0;
            r_hbytes_ff <= '0;
            r_mss_ff    <= '0;
            r_wscale_ff <= '0;
            r_found_ff  <= '0;
         end else begin
            r_src_ff    <= src_port_ff;
            r_dst_ff    <= dst_port_ff;
            r_seq_ff    <= seq_ff;
            r_ack_ff    <= ack_ff;
            r_flags_ff  <= flags_ff;
            r_win_ff    <= window_ff;
            r_csum_ff   <= csum_ff;
            r_hbytes_ff <= {offset_ff, 2'b00};
            r_mss_ff    <= opt_view.mss;
            r_wscale_ff <= opt_view.wscale;
            r_found_ff  <= opt_view.found;
         end
      end
   end

   assign rsp_bus.valid            = rsp_valid_ff;
   assign rsp_bus.source_port      = r_src_ff;
   assign rsp_bus.dest_port        = r_dst_ff;
   assign rsp_bus.sequence_number  = r_seq_ff;
   assign rsp_bus.ack_number       = r_ack_ff;
   assign rsp_bus.flag_bits        = r_flags_ff;
   assign rsp_bus.window_size      = r_win_ff;
   assign rsp_bus.header_checksum  = r_csum_ff;
   assign rsp_bus.header_bytes     = r_hbytes_ff;
   assign rsp_bus.max_segment_size = r_mss_ff;
   assign rsp_bus.window_scale     = r_wscale_ff;
   assign rsp_bus.options_found    = r_found_ff;
   assign rsp_bus.parse_status     = r_status_ff;

endmodule
